// ===== rtl/rv32i_instruction_decoder_top_assert.svh =====
// assertion macros for the rv32i decoder, clocked on clk, disabled in reset
`ifndef RV32I_INSTRUCTION_DECODER_TOP_ASSERT_SVH
`define RV32I_INSTRUCTION_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define RV32D_ASSERT_NOW(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("rv32d same-cycle check failed");

// next-cycle implication
`define RV32D_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("rv32d next-cycle check failed");

`endif

// ===== rtl/rv32d_pkg.sv =====
package rv32d_pkg;

	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_JAL    = 7'h6f;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_SYSTEM = 7'h73;

	localparam logic [11:0] F12_MRET  = 12'h302;
	localparam logic [31:0] WORD_ECALL = 32'h0000_0073;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	// alu funct3, shared by register and immediate forms
	localparam logic [2:0] F3_ADD_SUB = 3'd0;
	localparam logic [2:0] F3_SLL     = 3'd1;
	localparam logic [2:0] F3_SLT     = 3'd2;
	localparam logic [2:0] F3_SLTU    = 3'd3;
	localparam logic [2:0] F3_XOR     = 3'd4;
	localparam logic [2:0] F3_SRL_SRA = 3'd5;
	localparam logic [2:0] F3_OR      = 3'd6;
	localparam logic [2:0] F3_AND     = 3'd7;

	localparam logic [2:0] F3_LB  = 3'd0;
	localparam logic [2:0] F3_LH  = 3'd1;
	localparam logic [2:0] F3_LW  = 3'd2;
	localparam logic [2:0] F3_LBU = 3'd4;
	localparam logic [2:0] F3_LHU = 3'd5;

	localparam logic [2:0] F3_SB = 3'd0;
	localparam logic [2:0] F3_SH = 3'd1;
	localparam logic [2:0] F3_SW = 3'd2;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	typedef enum logic [2:0] {
		FMT_R     = 3'd0,
		FMT_I     = 3'd1,
		FMT_S     = 3'd2,
		FMT_B     = 3'd3,
		FMT_U     = 3'd4,
		FMT_J     = 3'd5,
		FMT_OTHER = 3'd6
	} fmt_t;

	typedef enum logic [5:0] {
		CODE_UNKNOWN   = 6'd0,
		CODE_NOMATCH   = 6'd1,
		CODE_ADD       = 6'd2,
		CODE_SUB       = 6'd3,
		CODE_SLL       = 6'd4,
		CODE_SLT       = 6'd5,
		CODE_SLTU      = 6'd6,
		CODE_XOR       = 6'd7,
		CODE_SRL       = 6'd8,
		CODE_SRA       = 6'd9,
		CODE_OR        = 6'd10,
		CODE_AND       = 6'd11,
		CODE_ADDI      = 6'd12,
		CODE_SLLI      = 6'd13,
		CODE_SLTI      = 6'd14,
		CODE_SLTIU     = 6'd15,
		CODE_XORI      = 6'd16,
		CODE_SRLI_SRAI = 6'd17,
		CODE_ORI       = 6'd18,
		CODE_ANDI      = 6'd19,
		CODE_LB        = 6'd20,
		CODE_LH        = 6'd21,
		CODE_LW        = 6'd22,
		CODE_LBU       = 6'd23,
		CODE_LHU       = 6'd24,
		CODE_SB        = 6'd25,
		CODE_SH        = 6'd26,
		CODE_SW        = 6'd27,
		CODE_BEQ       = 6'd28,
		CODE_BNE       = 6'd29,
		CODE_BLT       = 6'd30,
		CODE_BGE       = 6'd31,
		CODE_BLTU      = 6'd32,
		CODE_BGEU      = 6'd33,
		CODE_LUI       = 6'd34,
		CODE_AUIPC     = 6'd35,
		CODE_JAL       = 6'd36,
		CODE_JALR      = 6'd37,
		CODE_ECALL     = 6'd38,
		CODE_MRET      = 6'd39,
		CODE_SYSTEM    = 6'd40
	} code_t;

	typedef struct packed {
		logic [6:0]  opcode;
		logic [4:0]  rd;
		logic [2:0]  f3;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [6:0]  f7;
		fmt_t        fmt;
		logic [31:0] imm;
		code_t       code;
	} dec_t;

endpackage

// ===== rtl/rv32d_decode.sv =====
module rv32d_decode
	import rv32d_pkg::*;
(
	input  logic [31:0] instr,
	output dec_t        dec
);

	logic [31:0] iimm;

	assign iimm = {{20{instr[31]}}, instr[31:20]};

	always_comb begin
		dec.opcode = instr[6:0];
		dec.rd     = instr[11:7];
		dec.f3     = instr[14:12];
		dec.rs1    = instr[19:15];
		dec.rs2    = instr[24:20];
		dec.f7     = instr[31:25];
		dec.fmt    = FMT_OTHER;
		dec.imm    = '0;
		dec.code   = CODE_UNKNOWN;
		unique case (instr[6:0])
			OP_REG: begin
				dec.fmt = FMT_R;
				unique case (instr[14:12])
					F3_ADD_SUB: begin
						if (instr[31:25] == F7_BASE)
							dec.code = CODE_ADD;
						else if (instr[31:25] == F7_ALT)
							dec.code = CODE_SUB;
						else
							dec.code = CODE_NOMATCH;
					end
					F3_SLL:  dec.code = CODE_SLL;
					F3_SLT:  dec.code = CODE_SLT;
					F3_SLTU: dec.code = CODE_SLTU;
					F3_XOR:  dec.code = CODE_XOR;
					F3_SRL_SRA: begin
						if (instr[31:25] == F7_BASE)
							dec.code = CODE_SRL;
						else if (instr[31:25] == F7_ALT)
							dec.code = CODE_SRA;
						else
							dec.code = CODE_NOMATCH;
					end
					F3_OR:   dec.code = CODE_OR;
					default: dec.code = CODE_AND;
				endcase
			end
			OP_IMM: begin
				dec.fmt = FMT_I;
				dec.imm = iimm;
				unique case (instr[14:12])
					F3_ADD_SUB: dec.code = CODE_ADDI;
					F3_SLL:     dec.code = CODE_SLLI;
					F3_SLT:     dec.code = CODE_SLTI;
					F3_SLTU:    dec.code = CODE_SLTIU;
					F3_XOR:     dec.code = CODE_XORI;
					F3_SRL_SRA: dec.code = CODE_SRLI_SRAI;
					F3_OR:      dec.code = CODE_ORI;
					default:    dec.code = CODE_ANDI;
				endcase
			end
			OP_LOAD: begin
				dec.fmt = FMT_I;
				dec.imm = iimm;
				unique case (instr[14:12])
					F3_LB:   dec.code = CODE_LB;
					F3_LH:   dec.code = CODE_LH;
					F3_LW:   dec.code = CODE_LW;
					F3_LBU:  dec.code = CODE_LBU;
					F3_LHU:  dec.code = CODE_LHU;
					default: dec.code = CODE_NOMATCH;
				endcase
			end
			OP_STORE: begin
				dec.fmt = FMT_S;
				dec.imm = {{20{instr[31]}}, instr[31:25], instr[11:7]};
				unique case (instr[14:12])
					F3_SB:   dec.code = CODE_SB;
					F3_SH:   dec.code = CODE_SH;
					F3_SW:   dec.code = CODE_SW;
					default: dec.code = CODE_NOMATCH;
				endcase
			end
			OP_BRANCH: begin
				dec.fmt = FMT_B;
				dec.imm = {{20{instr[31]}}, instr[7], instr[30:25], instr[11:8], 1'b0};
				unique case (instr[14:12])
					F3_BEQ:  dec.code = CODE_BEQ;
					F3_BNE:  dec.code = CODE_BNE;
					F3_BLT:  dec.code = CODE_BLT;
					F3_BGE:  dec.code = CODE_BGE;
					F3_BLTU: dec.code = CODE_BLTU;
					F3_BGEU: dec.code = CODE_BGEU;
					default: dec.code = CODE_NOMATCH;
				endcase
			end
			OP_LUI: begin
				dec.fmt  = FMT_U;
				dec.imm  = {instr[31:12], 12'h000};
				dec.code = CODE_LUI;
			end
			OP_AUIPC: begin
				dec.fmt  = FMT_U;
				dec.imm  = {instr[31:12], 12'h000};
				dec.code = CODE_AUIPC;
			end
			OP_JAL: begin
				dec.fmt  = FMT_J;
				dec.imm  = {{12{instr[31]}}, instr[19:12], instr[20], instr[30:21], 1'b0};
				dec.code = CODE_JAL;
			end
			OP_JALR: begin
				dec.fmt  = FMT_I;
				dec.imm  = iimm;
				dec.code = CODE_JALR;
			end
			OP_SYSTEM: begin
				dec.fmt = FMT_I;
				dec.imm = iimm;
				if (instr == WORD_ECALL)
					dec.code = CODE_ECALL;
				else if (instr[31:20] == F12_MRET)
					dec.code = CODE_MRET;
				else
					dec.code = CODE_SYSTEM;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/rv32i_instruction_decoder_top.sv =====
// RV32I instruction decoder. Each transaction on the s side carries one 32-bit instruction
// word; the matching m transaction carries its fixed fields, format, sign-extended immediate
// and an instruction identity code. The block takes one instruction every clock cycle while
// s_tready is high and passes it through the input register, the decode logic and the result
// register. Backpressure on the m side stalls the result register, and the input register when
// it holds an instruction; s_tready drops only when both hold one and m_tready is low.
module rv32i_instruction_decoder_top
	import rv32d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // instruction
	output logic        m_tvalid,
	input  logic        m_tready,
	// major_opcode, dest_reg, minor_func, src_reg_a, src_reg_b, upper_func, immediate,
	// instr_code, zero pad
	output logic [71:0] m_tdata,
	output logic [2:0]  m_tuser    // format_kind
);

	logic        valid_s1;
	logic [31:0] instr_s1;
	logic        valid_s2;
	dec_t        result_s2;
	dec_t        dec;
	logic        en_s1;
	logic        en_s2;

	assign en_s2    = !valid_s2 || m_tready;
	assign en_s1    = !valid_s1 || en_s2;
	assign s_tready = en_s1;

	rv32d_decode u_decode (
		.instr (instr_s1),
		.dec   (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1)
				valid_s1 <= s_tvalid;
			if (en_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_tvalid)
			instr_s1 <= s_tdata;
		if (en_s2 && valid_s1)
			result_s2 <= dec;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, result_s2.code, result_s2.imm, result_s2.f7, result_s2.rs2,
		result_s2.rs1, result_s2.f3, result_s2.rd, result_s2.opcode};
	assign m_tuser  = result_s2.fmt;

`include "rv32i_instruction_decoder_top_assert.svh"

	`RV32D_ASSERT_NEXT(a_accept_loads_s1, s_tvalid && s_tready, valid_s1)
	`RV32D_ASSERT_NEXT(a_s1_to_s2, valid_s1 && en_s2, m_tvalid && m_tdata[6:0] == $past(instr_s1[6:0]))
	`RV32D_ASSERT_NOW(a_rtype_no_imm, m_tvalid && (m_tuser == FMT_R), m_tdata[63:32] == 32'h0)
	`RV32D_ASSERT_NOW(a_other_unknown, m_tvalid && m_tuser == FMT_OTHER, m_tdata[69:64] == CODE_UNKNOWN)

endmodule
